// ===== sv/tsa_pkg.sv =====
`default_nettype none

package tsa_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_DATA_WIDTH  = 32;

    localparam int KIND_W   = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH  = 5'd0,
        K_ADD   = 5'd1,
        K_SUB   = 5'd2,
        K_MUL   = 5'd3,
        K_DIV   = 5'd4,
        K_MOD   = 5'd5,
        K_GT    = 5'd6,
        K_GE    = 5'd7,
        K_LT    = 5'd8,
        K_LE    = 5'd9,
        K_EQ    = 5'd10,
        K_LAND  = 5'd11,
        K_LOR   = 5'd12,
        K_LNOT  = 5'd13,
        K_BAND  = 5'd14,
        K_BOR   = 5'd15,
        K_BXOR  = 5'd16,
        K_SHIFT = 5'd17,
        K_ISNUM = 5'd18
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_TYPE      = 3'd2,
        ST_DIV_ZERO  = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ===== sv/tsa_ram.sv =====
`default_nettype none

module tsa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tagged_stack_alu_unit.sv =====
// A push goes through the check and done states; a binary operation reads the top and second
// entries, executes and writes back; mul adds the iteration and fix states, and div or mod also
// take the absolute values of both operands first. One request is in flight at a time; the unit
// returns to idle, ready for the next request, as the result is registered. mul, div and mod take
// one bit per cycle through the shared adder, and the single stack memory port reads the two operands
// one after the other. Reset empties the stack and the output register; the stack memory is not cleared.
`default_nettype none

module tagged_stack_alu_unit #(
    parameter int STACK_DEPTH = tsa_pkg::DEF_STACK_DEPTH,
    parameter int DATA_WIDTH  = tsa_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic        [tsa_pkg::KIND_W-1:0]  kind,
    input  wire logic signed [tsa_pkg::VALUE_W-1:0] push_value,
    input  wire logic                               push_is_number,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic        [tsa_pkg::STATUS_W-1:0]     status,
    output logic signed [tsa_pkg::VALUE_W-1:0]      result_value,
    output logic        [tsa_pkg::DEPTH_W-1:0]      stack_depth
);

    import tsa_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = $clog2(DATA_WIDTH);
    localparam int IW = $clog2(DATA_WIDTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TOP,
        S_SEC,
        S_EXEC,
        S_ABSA,
        S_ABSB,
        S_ITER,
        S_FIX,
        S_WB,
        S_DONE
    } state_t;

    state_t          state_reg;
    kind_t           kind_reg;
    logic [DW-1:0]   pv_reg;
    logic            ptag_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DW-1:0]   a_reg;
    logic [DW-1:0]   b_reg;
    logic            tag_reg;
    logic            neg_a_reg;
    logic            neg_b_reg;
    logic [DW-1:0]   acc_reg;
    logic [DW-1:0]   work_reg;
    logic [IW-1:0]   iter_reg;
    logic [DW-1:0]   r_reg;
    status_t         st_pend_reg;
    logic [DW-1:0]   res_pend_reg;
    logic            out_valid_reg;
    status_t         status_reg;
    logic [VALUE_W-1:0] result_reg;
    logic [DEPTH_W-1:0] depth_reg;

    logic [DW:0]     add_x;
    logic [DW:0]     add_y;
    logic            add_sub;
    logic [DW:0]     add_sum;

    logic [DW:0]     ram_rdata;
    logic [DW:0]     ram_wdata;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic            ram_we;

    logic            need_two;
    logic            kind_known;
    logic            is_push;
    logic            full;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   cnt_m2;
    logic [CW-1:0]   wb_cnt;
    logic [DW-1:0]   top_val;
    logic            top_tag;
    logic [DW-1:0]   exec_r;
    logic [DW-1:0]   shift_r;
    logic signed [DW-1:0] a_signed;
    logic            lt_ab;
    logic            eq_ab;
    logic            div_bit;
    logic [DW:0]     div_trial;
    logic [DW-1:0]   dw_limit;
    logic [DW+VALUE_W-1:0] push_ext;
    logic [DW+VALUE_W-1:0] res_ext;
    logic [CW+DEPTH_W-1:0] cnt_ext;

    tsa_ram #(
        .WIDTH(DW + 1),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign push_ext   = {{DW{push_value[VALUE_W-1]}}, push_value};
    assign res_ext    = {{VALUE_W{1'b0}}, res_pend_reg};
    assign cnt_ext    = {{DEPTH_W{1'b0}}, cnt_reg};
    assign dw_limit   = DW'(DATA_WIDTH);
    assign need_two   = !(kind_reg == K_LNOT || kind_reg == K_ISNUM);
    assign kind_known = (kind_reg <= K_ISNUM);
    assign is_push    = (kind_reg == K_PUSH);
    assign full       = (cnt_reg == CW'(STACK_DEPTH));
    assign cnt_m1     = cnt_reg - CW'(1);
    assign cnt_m2     = cnt_reg - CW'(2);
    assign wb_cnt     = need_two ? cnt_m2 : cnt_m1;
    assign top_val    = ram_rdata[DW-1:0];
    assign top_tag    = ram_rdata[DW];
    assign a_signed   = a_reg;
    assign div_trial  = {acc_reg, work_reg[DW-1]};

    assign ram_raddr = (state_reg == S_TOP) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
    assign ram_we    = ((state_reg == S_CHECK) && is_push && !full) || (state_reg == S_WB);
    assign ram_waddr = (state_reg == S_WB) ? wb_cnt[AW-1:0] : cnt_reg[AW-1:0];
    assign ram_wdata = (state_reg == S_WB) ? {1'b1, r_reg} : {ptag_reg, pv_reg};

    // Shared adder: data adds and subtracts, ordering compares, negations and iteration steps.
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (state_reg)
            S_EXEC:
            begin
                if (kind_reg == K_SHIFT)
                begin
                    add_y   = {b_reg[DW-1], b_reg};
                    add_sub = 1'b1;
                end
                else
                begin
                    add_x   = {a_reg[DW-1], a_reg};
                    add_y   = {b_reg[DW-1], b_reg};
                    add_sub = (kind_reg != K_ADD);
                end
            end
            S_ABSA:
            begin
                add_y   = {1'b0, a_reg};
                add_sub = 1'b1;
            end
            S_ABSB:
            begin
                add_y   = {1'b0, b_reg};
                add_sub = 1'b1;
            end
            S_ITER:
            begin
                if (kind_reg == K_MUL)
                begin
                    add_x = {1'b0, acc_reg[DW-2:0], 1'b0};
                    add_y = {1'b0, work_reg[DW-1] ? a_reg : {DW{1'b0}}};
                end
                else
                begin
                    add_x   = div_trial;
                    add_y   = {1'b0, b_reg};
                    add_sub = 1'b1;
                end
            end
            S_FIX:
            begin
                add_y   = {1'b0, (kind_reg == K_DIV) ? work_reg : acc_reg};
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_x + (add_y ^ {(DW + 1){add_sub}}) + (DW + 1)'(add_sub);
    end

    assign div_bit = !add_sum[DW];
    assign lt_ab   = add_sum[DW];
    assign eq_ab   = (a_reg == b_reg);

    // A positive count shifts left; otherwise the adder supplies the negated count.
    always_comb
    begin
        if (!b_reg[DW-1] && (b_reg != '0))
        begin
            shift_r = (b_reg < dw_limit) ? (a_reg << b_reg[SW-1:0]) : '0;
        end
        else if (add_sum[DW-1:0] < dw_limit)
        begin
            shift_r = a_signed >>> add_sum[SW-1:0];
        end
        else
        begin
            shift_r = {DW{a_reg[DW-1]}};
        end
    end

    always_comb
    begin
        unique case (kind_reg)
            K_ADD, K_SUB: exec_r = add_sum[DW-1:0];
            K_GT:         exec_r = DW'(!lt_ab && !eq_ab);
            K_GE:         exec_r = DW'(!lt_ab);
            K_LT:         exec_r = DW'(lt_ab);
            K_LE:         exec_r = DW'(lt_ab || eq_ab);
            K_EQ:         exec_r = DW'(eq_ab);
            K_LAND:       exec_r = DW'((a_reg != '0) && (b_reg != '0));
            K_LOR:        exec_r = DW'((a_reg != '0) || (b_reg != '0));
            K_LNOT:       exec_r = DW'(b_reg == '0);
            K_BAND:       exec_r = a_reg & b_reg;
            K_BOR:        exec_r = a_reg | b_reg;
            K_BXOR:       exec_r = a_reg ^ b_reg;
            K_SHIFT:      exec_r = shift_r;
            K_ISNUM:      exec_r = DW'(tag_reg);
            default:      exec_r = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            result_reg    <= '0;
            depth_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        kind_reg  <= kind_t'(kind);
                        pv_reg    <= push_ext[DW-1:0];
                        ptag_reg  <= push_is_number;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    st_pend_reg  <= ST_OK;
                    res_pend_reg <= '0;
                    state_reg    <= S_DONE;
                    if (is_push)
                    begin
                        if (full)
                        begin
                            st_pend_reg <= ST_FULL;
                        end
                        else
                        begin
                            cnt_reg      <= cnt_reg + CW'(1);
                            res_pend_reg <= pv_reg;
                        end
                    end
                    else if (!kind_known)
                    begin
                        if (cnt_reg != '0)
                        begin
                            state_reg <= S_TOP;
                        end
                    end
                    else if ((cnt_reg == '0) || (need_two && (cnt_reg < CW'(2))))
                    begin
                        st_pend_reg <= ST_UNDERFLOW;
                    end
                    else
                    begin
                        state_reg <= S_TOP;
                    end
                end
                S_TOP:
                begin
                    b_reg   <= top_val;
                    tag_reg <= top_tag;
                    if (!kind_known)
                    begin
                        res_pend_reg <= top_val;
                        state_reg    <= S_DONE;
                    end
                    else if ((kind_reg != K_ISNUM) && !top_tag)
                    begin
                        st_pend_reg <= ST_TYPE;
                        state_reg   <= S_DONE;
                    end
                    else if (need_two)
                    begin
                        state_reg <= S_SEC;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_SEC:
                begin
                    a_reg <= top_val;
                    if (!top_tag)
                    begin
                        st_pend_reg <= ST_TYPE;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    neg_a_reg <= a_reg[DW-1];
                    neg_b_reg <= b_reg[DW-1];
                    acc_reg   <= '0;
                    iter_reg  <= IW'(DATA_WIDTH - 1);
                    if (kind_reg == K_DIV || kind_reg == K_MOD)
                    begin
                        if (b_reg == '0)
                        begin
                            st_pend_reg <= ST_DIV_ZERO;
                            state_reg   <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_ABSA;
                        end
                    end
                    else if (kind_reg == K_MUL)
                    begin
                        work_reg  <= b_reg;
                        state_reg <= S_ITER;
                    end
                    else
                    begin
                        r_reg     <= exec_r;
                        state_reg <= S_WB;
                    end
                end
                S_ABSA:
                begin
                    work_reg  <= neg_a_reg ? add_sum[DW-1:0] : a_reg;
                    state_reg <= S_ABSB;
                end
                S_ABSB:
                begin
                    b_reg     <= neg_b_reg ? add_sum[DW-1:0] : b_reg;
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (kind_reg == K_MUL)
                    begin
                        acc_reg  <= add_sum[DW-1:0];
                        work_reg <= {work_reg[DW-2:0], 1'b0};
                    end
                    else
                    begin
                        acc_reg  <= div_bit ? add_sum[DW-1:0] : div_trial[DW-1:0];
                        work_reg <= {work_reg[DW-2:0], div_bit};
                    end
                    iter_reg <= iter_reg - IW'(1);
                    if (iter_reg == '0)
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    priority if (kind_reg == K_MUL)
                    begin
                        r_reg <= acc_reg;
                    end
                    else if (kind_reg == K_DIV)
                    begin
                        r_reg <= (neg_a_reg ^ neg_b_reg) ? add_sum[DW-1:0] : work_reg;
                    end
                    else
                    begin
                        r_reg <= neg_a_reg ? add_sum[DW-1:0] : acc_reg;
                    end
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    cnt_reg      <= wb_cnt + CW'(1);
                    st_pend_reg  <= ST_OK;
                    res_pend_reg <= r_reg;
                    state_reg    <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= st_pend_reg;
                        result_reg    <= (st_pend_reg == ST_OK) ? res_ext[VALUE_W-1:0] : '0;
                        depth_reg     <= cnt_ext[DEPTH_W-1:0];
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign stack_depth  = depth_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while an item is in flight");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> result_value == '0)
        else $error("nonzero result on an error status");

    a_iter_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ITER) && (iter_reg != '0) |=> state_reg == S_ITER)
        else $error("iteration left early");

    a_underflow_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_UNDERFLOW) |-> stack_depth < DEPTH_W'(2))
        else $error("underflow reported with two or more entries");

endmodule

`default_nettype wire
